/* rtl/image_centroid_second_moments_assert.svh */
// Assertion macros shared by the image moments RTL.
`ifndef IMAGE_CENTROID_SECOND_MOMENTS_ASSERT_SVH
`define IMAGE_CENTROID_SECOND_MOMENTS_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ICSM_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ICSM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

/* rtl/icsm_pkg.sv */
// Package with the word types and constants of the image moments block.
`timescale 1ns / 1ps
package icsm_pkg;

  // Largest row width that the column counter covers.
  localparam int MaxWidth = 256;
  localparam int ColW     = $clog2(MaxWidth);

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgRowWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartX   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStartY   = 2'd2;

  // Input word: one pixel weight and the end-of-image flag.
  typedef struct packed {
    logic signed [15:0] pixel;
    logic               last;
  } pix_t;

  // Output word: centroid offsets, central moments and the ellipse flag.
  typedef struct packed {
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic signed [39:0] var_xx;
    logic signed [39:0] var_yy;
    logic signed [39:0] cov_xy;
    logic               valid_res;
  } res_t;

endpackage

/* rtl/image_centroid_second_moments.sv */
// Top level of the image moments block: centroid and central second moments.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid_i, in_stall_o, in_word_i) carries one pixel weight
//   per word, raster order, with the last flag on the final pixel of an image.
//   Output channel (out_valid_o, out_stall_i, out_word_o) carries one word per
//   image with the centroid offsets, the three central moments and a flag
//   that is set when the moments describe an ellipse.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets the row
//   width and the x and y start offsets; write it between images.
// Timing
//   One shared 34 by 34 bit multiplier does all products. A pixel takes five
//   products and the last accumulate, and no new pixel is accepted before the
//   last step of the one in hand. After the last pixel, the mean pass runs,
//   then the central moment and ellipse test passes on the same multiplier;
//   the result word is formed when the ellipse test ends.
//   The result sits in an output register, so pixels of the next image are
//   taken while it waits. If a second result is ready before the first is
//   taken, the block holds it and stalls the input.
// Reset sets the sums, counters, control and config registers to defaults.
module image_centroid_second_moments (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [icsm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [icsm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  icsm_pkg::pix_t                  in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output icsm_pkg::res_t                  out_word_o
);
  import icsm_pkg::*;

`include "image_centroid_second_moments_assert.svh"

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPix  = 3'd1;
  localparam logic [2:0] StMean = 3'd2;
  localparam logic [2:0] StCtr  = 3'd3;
  localparam logic [2:0] StVal  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  localparam logic [3:0] PixLast = 4'd5;
  localparam logic [3:0] CtrLast = 4'd3;
  localparam logic [3:0] ValLast = 4'd8;

  localparam int AccW = 82;

  logic [2:0]          state_q, state_d;
  logic [3:0]          step_q, step_d;

  logic [8:0]          row_width_q;
  logic signed [15:0]  start_x_q, start_y_q;
  logic [ColW-1:0]     column_q;
  logic signed [17:0]  cur_y_q;
  logic [47:0]         sum_x_q, sum_y_q;
  logic [63:0]         sum_xx_q, sum_yy_q, sum_xy_q;

  logic signed [15:0]  p_q;
  logic                last_q;
  logic signed [17:0]  x_q, y_q;
  logic signed [33:0]  xp_q, yp_q;
  logic signed [63:0]  prod_q;
  logic signed [31:0]  mqx_q, mqy_q;
  logic [2:0]          ppk_q;
  logic signed [AccW-1:0] acc_q;
  res_t                res_q;

  logic                out_valid_q;
  res_t                out_q;

  // Rounded, saturated scalings of the sums.
  function automatic logic signed [23:0] mean24(input logic [47:0] v);
    logic signed [33:0] r;
    r = $signed({v[47], v[47:15]}) + $signed({33'd0, v[14]});
    if (r[33:23] != {11{r[33]}}) begin
      return r[33] ? 24'sh800000 : 24'sh7FFFFF;
    end
    return r[23:0];
  endfunction

  function automatic logic signed [31:0] mean32(input logic [47:0] v);
    logic signed [41:0] r;
    r = $signed({v[47], v[47:7]}) + $signed({41'd0, v[6]});
    if (r[41:31] != {11{r[41]}}) begin
      return r[41] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    return r[31:0];
  endfunction

  function automatic logic signed [39:0] central40(input logic [63:0] raw,
                                                  input logic signed [63:0] mm);
    logic signed [49:0] a;
    logic signed [48:0] b;
    logic signed [50:0] d;
    a = $signed({raw[63], raw[63:15]}) + $signed({49'd0, raw[14]});
    b = $signed({mm[63], mm[63:16]}) + $signed({48'd0, mm[15]});
    d = 51'(a) - 51'(b);
    if (d[50:39] != {12{d[50]}}) begin
      return d[50] ? 40'sh8000000000 : 40'sh7FFFFFFFFF;
    end
    return d[39:0];
  endfunction

  // Handshake.
  logic in_ready, in_acc, out_load, pix_end;
  assign pix_end  = (state_q == StPix) && (step_q == PixLast);
  assign in_ready = (state_q == StIdle) || (pix_end && !last_q);
  assign in_acc   = in_valid_i && in_ready;
  assign out_load = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Coordinates of the pixel being accepted and the row step.
  logic [8:0]         w_eff;
  logic signed [17:0] x_new;
  logic               row_end;
  always_comb begin
    if (row_width_q == 9'd0) begin
      w_eff = 9'd1;
    end else if (row_width_q > 9'(MaxWidth)) begin
      w_eff = 9'(MaxWidth);
    end else begin
      w_eff = row_width_q;
    end
    x_new   = 18'(start_x_q) + $signed({2'b00, column_q, 8'h00});
    row_end = ({1'b0, column_q} + 9'd1) >= w_eff;
  end

  // Magnitude halves for the ellipse test.
  logic [39:0] cabs;
  logic [19:0] ta, tb;
  always_comb begin
    cabs = res_q.cov_xy[39] ? 40'(-res_q.cov_xy) : 40'(res_q.cov_xy);
    case (step_q[2])
      1'b0: begin
        ta = step_q[1] ? res_q.var_xx[39:20] : res_q.var_xx[19:0];
        tb = step_q[0] ? res_q.var_yy[39:20] : res_q.var_yy[19:0];
      end
      default: begin
        ta = step_q[1] ? cabs[39:20] : cabs[19:0];
        tb = step_q[0] ? cabs[39:20] : cabs[19:0];
      end
    endcase
  end

  // Operand select for the shared multiplier.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StPix: begin
        case (step_q)
          4'd0: begin mul_a = 34'(x_q);  mul_b = 34'(p_q); end
          4'd1: begin mul_a = 34'(y_q);  mul_b = 34'(p_q); end
          4'd2: begin mul_a = xp_q;      mul_b = 34'(x_q); end
          4'd3: begin mul_a = yp_q;      mul_b = 34'(y_q); end
          4'd4: begin mul_a = xp_q;      mul_b = 34'(y_q); end
          default: begin mul_a = '0;     mul_b = '0; end
        endcase
      end
      StCtr: begin
        case (step_q)
          4'd0: begin mul_a = 34'(mqx_q); mul_b = 34'(mqx_q); end
          4'd1: begin mul_a = 34'(mqy_q); mul_b = 34'(mqy_q); end
          4'd2: begin mul_a = 34'(mqx_q); mul_b = 34'(mqy_q); end
          default: begin mul_a = '0;      mul_b = '0; end
        endcase
      end
      StVal: begin
        mul_a = $signed({14'd0, ta});
        mul_b = $signed({14'd0, tb});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Partial product term of the ellipse test, shifted into place.
  logic [AccW-1:0] term;
  always_comb begin
    case ({1'b0, ppk_q[1]} + {1'b0, ppk_q[0]})
      2'd0:    term = AccW'(prod_q[40:0]);
      2'd1:    term = AccW'(prod_q[40:0]) << 20;
      default: term = AccW'(prod_q[40:0]) << 40;
    endcase
  end

  // Next value of the ellipse test accumulator.
  logic signed [AccW-1:0] acc_d;
  assign acc_d = ppk_q[2] ? acc_q - $signed(term) : acc_q + $signed(term);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StPix;
          step_d  = 4'd0;
        end
      end
      StPix: begin
        if (step_q == PixLast) begin
          step_d = 4'd0;
          if (last_q) begin
            state_d = StMean;
          end else if (in_acc) begin
            state_d = StPix;
          end else begin
            state_d = StIdle;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StMean: begin
        state_d = StCtr;
        step_d  = 4'd0;
      end
      StCtr: begin
        if (step_q == CtrLast) begin
          state_d = StVal;
          step_d  = 4'd0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StVal: begin
        if (step_q == ValLast) begin
          state_d = StDone;
          step_d  = 4'd0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
        step_d  = 4'd0;
      end
    endcase
  end

  // Control state, configuration, position counters and sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= 4'd0;
      row_width_q <= 9'd1;
      start_x_q   <= '0;
      start_y_q   <= '0;
      column_q    <= '0;
      cur_y_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_xx_q    <= '0;
      sum_yy_q    <= '0;
      sum_xy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;

      // Advance column and row on each accepted pixel.
      if (in_acc) begin
        if (row_end) begin
          column_q <= '0;
          cur_y_q  <= cur_y_q + 18'sd256;
        end else begin
          column_q <= column_q + 1'b1;
        end
      end

      // Accumulate the product issued in the previous cycle.
      if (state_q == StPix) begin
        case (step_q)
          4'd1: sum_x_q  <= sum_x_q + prod_q[47:0];
          4'd2: sum_y_q  <= sum_y_q + prod_q[47:0];
          4'd3: sum_xx_q <= sum_xx_q + prod_q;
          4'd4: sum_yy_q <= sum_yy_q + prod_q;
          4'd5: sum_xy_q <= sum_xy_q + prod_q;
          default: ;
        endcase
      end

      // Result hand-off and restart for the next image.
      if (out_load) begin
        out_valid_q <= 1'b1;
        column_q    <= '0;
        cur_y_q     <= 18'(start_y_q);
        sum_x_q     <= '0;
        sum_y_q     <= '0;
        sum_xx_q    <= '0;
        sum_yy_q    <= '0;
        sum_xy_q    <= '0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRowWidth: row_width_q <= cfg_data_i[8:0];
          CfgStartX:   start_x_q   <= $signed(cfg_data_i);
          CfgStartY: begin
            start_y_q <= $signed(cfg_data_i);
            cur_y_q   <= 18'($signed(cfg_data_i));
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[63:0];

    if (in_acc) begin
      p_q    <= in_word_i.pixel;
      last_q <= in_word_i.last;
      x_q    <= x_new;
      y_q    <= cur_y_q;
    end

    // Keep the first-moment products for the second-moment passes.
    if (state_q == StPix && step_q == 4'd1) begin
      xp_q <= prod_q[33:0];
    end
    if (state_q == StPix && step_q == 4'd2) begin
      yp_q <= prod_q[33:0];
    end

    // Means.
    if (state_q == StMean) begin
      mqx_q        <= mean32(sum_x_q);
      mqy_q        <= mean32(sum_y_q);
      res_q.mean_x <= mean24(sum_x_q);
      res_q.mean_y <= mean24(sum_y_q);
    end

    // Central moments.
    if (state_q == StCtr) begin
      case (step_q)
        4'd1: res_q.var_xx <= central40(sum_xx_q, prod_q);
        4'd2: res_q.var_yy <= central40(sum_yy_q, prod_q);
        4'd3: res_q.cov_xy <= central40(sum_xy_q, prod_q);
        default: ;
      endcase
    end

    // Ellipse test: accumulate var_xx*var_yy minus cov_xy squared.
    if (state_q == StCtr) begin
      acc_q <= '0;
    end
    if (state_q == StVal) begin
      ppk_q <= step_q[2:0];
      if (step_q != 4'd0) begin
        acc_q <= acc_d;
      end
      // The last partial product settles the ellipse flag.
      if (step_q == ValLast) begin
        res_q.valid_res <= !res_q.var_xx[39] && !res_q.var_yy[39] && !acc_d[AccW-1];
      end
    end

    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Checks on the sequencer.
  `ICSM_ASSERT_NEXT(a_acc_stalls, in_valid_i && !in_stall_o, in_stall_o)
  `ICSM_ASSERT_IMPLY(a_pix_step, state_q == StPix, step_q <= PixLast)
  `ICSM_ASSERT_NEXT(a_res_held, state_q == StDone && out_valid_q && out_stall_i,
                    state_q == StDone)
  `ICSM_ASSERT_NEXT(a_pix_to_idle, pix_end && !last_q && !in_valid_i, state_q == StIdle)

endmodule

/* tb/tb.sv */
// Self-checking testbench for the image moments block: pixel driver, result checker, watchdog.
`timescale 1ns / 1ps
module tb;
  import icsm_pkg::*;

  // Spare index above the register list; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int RandomPixels  = 1700;
  localparam int SettleCycles  = 40;
  localparam int HoldoffCycles = 400;
  localparam int WatchdogLimit = 3000;
  localparam int IdlePercent   = 9;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pix_t                in_word_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  res_t                out_word_o;

  image_centroid_second_moments dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Pixels waiting to be offered and moment words waiting to be seen.
  pix_t pending_pixels_q[$];
  res_t expected_moments_q[$];

  // Shadow copy of the registers and of the accumulator state.
  logic [8:0]  shadow_width;
  logic [15:0] shadow_start_x;
  logic [15:0] shadow_start_y;
  int unsigned column_q;
  logic [17:0] row_y_q;
  logic [47:0] acc_x, acc_y;
  logic [63:0] acc_xx, acc_yy, acc_xy;

  int err_count       = 0;
  int pixels_accepted = 0;
  int images_checked  = 0;
  int ellipse_count   = 0;
  int setting_count   = 0;
  int pushed_pixels   = 0;
  int idle_pct        = IdlePercent;
  int holdoff_req     = 0;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // Shift right by s with rounding half up.
  function automatic longint round_shift(input longint v, input int s);
    return (v >>> s) + ((v >>> (s - 1)) & 64'sd1);
  endfunction

  function automatic longint sat_to(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Raw second moment minus the product of the two inner means.
  function automatic longint central_moment(input logic [63:0] raw, input longint ma,
                                            input longint mb);
    return sat_to(round_shift($signed(raw), 15) - round_shift(ma * mb, 16), 40);
  endfunction

  task automatic restart_image();
    column_q = 0;
    row_y_q  = {{2{shadow_start_y[15]}}, shadow_start_y};
    acc_x    = '0;
    acc_y    = '0;
    acc_xx   = '0;
    acc_yy   = '0;
    acc_xy   = '0;
  endtask

  // Folds one accepted pixel into the sums; on the last pixel forms the moment word.
  task automatic accumulate_pixel(input pix_t w, output bit produced, output res_t r);
    longint p, x, y, mqx, mqy, vxx, vyy, cxy;
    int unsigned wd;
    logic [47:0] ua, ub, uc;
    logic [95:0] lhs, rhs;
    produced = 1'b0;
    r = '0;
    wd = shadow_width;
    if (wd == 0) wd = 1;
    if (wd > MaxWidth) wd = MaxWidth;
    p = longint'($signed(w.pixel));
    x = longint'($signed(shadow_start_x)) + longint'(column_q) * 256;
    y = longint'($signed(row_y_q));
    acc_x  = acc_x + 48'(x * p);
    acc_y  = acc_y + 48'(y * p);
    acc_xx = acc_xx + 64'(x * x * p);
    acc_yy = acc_yy + 64'(y * y * p);
    acc_xy = acc_xy + 64'(x * y * p);
    // A column at or past the row width ends the row.
    if (column_q + 1 >= wd) begin
      column_q = 0;
      row_y_q  = row_y_q + 18'd256;
    end else begin
      column_q++;
    end
    if (w.last) begin
      produced    = 1'b1;
      r.mean_x    = 24'(sat_to(round_shift(longint'($signed(acc_x)), 15), 24));
      r.mean_y    = 24'(sat_to(round_shift(longint'($signed(acc_y)), 15), 24));
      mqx = sat_to(round_shift(longint'($signed(acc_x)), 7), 32);
      mqy = sat_to(round_shift(longint'($signed(acc_y)), 7), 32);
      vxx = central_moment(acc_xx, mqx, mqx);
      vyy = central_moment(acc_yy, mqy, mqy);
      cxy = central_moment(acc_xy, mqx, mqy);
      r.var_xx = 40'(vxx);
      r.var_yy = 40'(vyy);
      r.cov_xy = 40'(cxy);
      // Ellipse test on the saturated moments, in full precision.
      r.valid_res = 1'b0;
      if (vxx >= 0 && vyy >= 0) begin
        ua  = 48'(vxx);
        ub  = 48'(vyy);
        uc  = 48'(cxy < 0 ? -cxy : cxy);
        lhs = ua * ub;
        rhs = uc * uc;
        r.valid_res = (lhs >= rhs);
      end
      restart_image();
    end
  endtask

  // Pixel driver: predicts each accepted word, then offers the next one.
  always @(posedge clk_i) begin : pixel_driver
    bit   produced;
    res_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_pixel(in_word_i, produced, r);
        if (produced) expected_moments_q.push_back(r);
        pixels_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pixels_q.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_word_i  <= pending_pixels_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result checker and receiver stall, including the long hold-off.
  always @(posedge clk_i) begin : moment_checker
    res_t want;
    int   holdoff_left;
    int   holdoff_seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_moments_q.size() == 0) begin
          report_mismatch("moment word arrived with no image pending");
        end else begin
          want = expected_moments_q.pop_front();
          if (out_word_o.mean_x !== want.mean_x)
            report_mismatch($sformatf("image %0d mean_x: got %0d, expected %0d",
                            images_checked, out_word_o.mean_x, want.mean_x));
          if (out_word_o.mean_y !== want.mean_y)
            report_mismatch($sformatf("image %0d mean_y: got %0d, expected %0d",
                            images_checked, out_word_o.mean_y, want.mean_y));
          if (out_word_o.var_xx !== want.var_xx)
            report_mismatch($sformatf("image %0d var_xx: got %0d, expected %0d",
                            images_checked, out_word_o.var_xx, want.var_xx));
          if (out_word_o.var_yy !== want.var_yy)
            report_mismatch($sformatf("image %0d var_yy: got %0d, expected %0d",
                            images_checked, out_word_o.var_yy, want.var_yy));
          if (out_word_o.cov_xy !== want.cov_xy)
            report_mismatch($sformatf("image %0d cov_xy: got %0d, expected %0d",
                            images_checked, out_word_o.cov_xy, want.cov_xy));
          if (out_word_o.valid_res !== want.valid_res)
            report_mismatch($sformatf("image %0d valid_res: got %0b, expected %0b",
                            images_checked, out_word_o.valid_res, want.valid_res));
          if (want.valid_res) ellipse_count++;
        end
        images_checked++;
      end
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HoldoffCycles;
        out_stall_i <= 1'b1;
      end else if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < idle_pct);
      end
    end else begin
      holdoff_left = 0;
      holdoff_seen = 0;
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("Timeout after %0d quiet cycles", quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end else begin
      quiet = 0;
    end
  end

  // Register write; the shadow copy follows the same rules as the block.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgRowWidth: shadow_width = data[8:0];
      CfgStartX:   shadow_start_x = data;
      CfgStartY: begin
        shadow_start_y = data;
        row_y_q = {{2{data[15]}}, data};
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_pixel(input logic [15:0] v, input bit last);
    pix_t w;
    w.pixel = v;
    w.last  = last;
    pending_pixels_q.push_back(w);
    pushed_pixels++;
  endtask

  // Mostly non-negative weights that add up to about one, with a little noise.
  task automatic push_weighted_image(input int n);
    int remaining, share;
    remaining = 32768;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) == 0) begin
        share = -$urandom_range(200, 0);
      end else if (i == n - 1) begin
        share = (remaining > 32767) ? 32767 : remaining;
      end else begin
        share = $urandom_range(2 * remaining / (n - i), 0);
        if (share > 32767) share = 32767;
      end
      if (share > 0) remaining -= share;
      push_pixel(16'(share), i == n - 1);
    end
  endtask

  // Arbitrary signed pixels; without a last flag the image runs on.
  task automatic push_noise_image(input int n, input bit close);
    for (int i = 0; i < n; i++) push_pixel(16'($urandom), close && (i == n - 1));
  endtask

  // Long images of full-scale pixels to drive the outputs into saturation.
  task automatic push_extreme_image(input int n);
    logic [15:0] v;
    v = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
    for (int i = 0; i < n; i++) begin
      push_pixel(($urandom_range(15, 0) == 0) ? 16'($urandom) : v, i == n - 1);
    end
  endtask

  // Waits until every word is taken and every result seen, then lets the block settle.
  task automatic drain_block();
    do @(posedge clk_i);
    while (pending_pixels_q.size() != 0 || in_valid_i || expected_moments_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(4, 0))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int          rand_base;
    int          target;
    int          kind;
    int          phase;
    logic [15:0] wdata;
    shadow_width   = 9'd1;
    shadow_start_x = '0;
    shadow_start_y = '0;
    restart_image();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults with full-scale pixels of both signs.
    push_pixel(16'h7FFF, 1'b0);
    push_pixel(16'h8000, 1'b1);
    drain_block();
    // Row width zero acts as one; extreme offsets.
    write_reg(CfgRowWidth, 16'h0000);
    write_reg(CfgStartX, 16'h7FFF);
    write_reg(CfgStartY, 16'h8000);
    setting_count++;
    push_pixel(16'h7FFF, 1'b0);
    push_pixel(16'h7FFF, 1'b0);
    push_pixel(16'h8000, 1'b1);
    drain_block();
    // All width bits set: clamps to the maximum width.
    write_reg(CfgRowWidth, 16'hFFFF);
    write_reg(CfgStartX, 16'h8000);
    write_reg(CfgStartY, 16'h7FFF);
    setting_count++;
    push_pixel(16'h7FFF, 1'b0);
    push_pixel(16'h8000, 1'b0);
    push_pixel(16'h0001, 1'b0);
    push_pixel(16'hFFFF, 1'b1);
    drain_block();
    // Exactly the maximum width.
    write_reg(CfgRowWidth, 16'(MaxWidth));
    setting_count++;
    repeat (2) push_pixel(16'h7FFF, 1'b0);
    push_pixel(16'h7FFF, 1'b1);
    drain_block();
    // Narrow rows with weights that sum to one, then an all-zero image.
    write_reg(CfgRowWidth, 16'd3);
    write_reg(CfgStartX, 16'hFF00);
    write_reg(CfgStartY, 16'hFF00);
    setting_count++;
    for (int i = 0; i < 4; i++) push_pixel(16'h2000, i == 3);
    push_pixel(16'h0000, 1'b1);
    drain_block();
    // Width and start_y rewritten in mid-image, column already past the new width.
    write_reg(CfgRowWidth, 16'd4);
    repeat (3) push_pixel(16'h1000, 1'b0);
    drain_block();
    write_reg(CfgRowWidth, 16'd2);
    write_reg(CfgStartY, 16'h0080);
    write_reg(CfgSpare, 16'hFFFF);
    setting_count++;
    push_pixel(16'h1000, 1'b0);
    push_pixel(16'h1000, 1'b1);
    drain_block();

    // Random phases, each with a fresh register setting.
    rand_base = pushed_pixels;
    phase = 0;
    while (pushed_pixels - rand_base < RandomPixels) begin
      case ($urandom_range(5, 0))
        0:       wdata = 16'd1;
        1:       wdata = 16'(MaxWidth);
        2:       wdata = 16'($urandom_range(16, 2));
        3:       wdata = 16'($urandom);
        default: wdata = 16'($urandom_range(64, 1));
      endcase
      write_reg(CfgRowWidth, wdata);
      write_reg(CfgStartX, pick_offset());
      write_reg(CfgStartY, pick_offset());
      if ($urandom_range(3, 0) == 0) write_reg(CfgSpare, 16'($urandom));
      setting_count++;
      idle_pct = (phase == 2) ? 0 : IdlePercent;
      if (phase == 4) holdoff_req <= holdoff_req + 1;
      target = pushed_pixels + 150;
      while (pushed_pixels < target) begin
        kind = $urandom_range(99, 0);
        if (phase == 4)    push_weighted_image($urandom_range(3, 1));
        else if (kind < 75) push_weighted_image($urandom_range(24, 1));
        else if (kind < 85) push_noise_image($urandom_range(40, 1), 1'b1);
        else if (kind < 88) push_extreme_image($urandom_range(300, 100));
        else if (kind < 93) push_noise_image($urandom_range(10, 1), 1'b0);
        else                push_noise_image(1, 1'b1);
      end
      drain_block();
      phase++;
    end

    $display("Checked %0d images from %0d pixels under %0d register settings.",
             images_checked, pixels_accepted, setting_count);
    $display("Ellipse flag set on %0d images; one long output hold-off applied.",
             ellipse_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
